>>> rtl/hcoh_pkg.sv
// Shared widths, register codes, reset values and control structs for the HOG cell histogram.
package hcoh_pkg;

    // Payload and register widths
    localparam int MAG_W       = 16;
    localparam int DIR_W       = 16;
    localparam int BIN_IDX_W   = 4;
    localparam int BIN_VAL_W   = 32;
    localparam int NUM_BINS_W  = 5;
    localparam int THETA_MAX_W = 9;
    localparam int BIN_WIDTH_W = 8;
    localparam int BIN_SCALE_W = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Fixed point: angles Q9.7, bin position Q.23
    localparam int ANG_FRAC  = 7;
    localparam int FRAC_BITS = 23;
    localparam int POS_W     = DIR_W + BIN_SCALE_W;
    localparam int AW_W      = FRAC_BITS + 1;

    localparam int MAX_BINS_DEF = 16;

    localparam logic INTERP_NEAREST  = 1'b0;
    localparam logic INTERP_BILINEAR = 1'b1;

    localparam logic [NUM_BINS_W-1:0]  NUM_BINS_RST    = 5'd9;
    localparam logic [THETA_MAX_W-1:0] THETA_MAX_RST   = 9'd360;
    localparam logic [BIN_WIDTH_W-1:0] BIN_WIDTH_RST   = 8'd40;
    localparam logic [BIN_SCALE_W-1:0] BIN_SCALE_RST   = 16'd1638;
    localparam logic                   INTERP_MODE_RST = INTERP_BILINEAR;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_BINS    = 3'd0,
        CFG_THETA_MAX   = 3'd1,
        CFG_BIN_WIDTH   = 3'd2,
        CFG_BIN_SCALE   = 3'd3,
        CFG_INTERP_MODE = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [THETA_MAX_W-1:0] theta_max;
        logic [BIN_WIDTH_W-1:0] bin_width;
        logic [BIN_SCALE_W-1:0] bin_scale;
        logic                   interp_mode;
    } t_cfg;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_all;
    } t_mem_ctl;

endpackage

>>> rtl/hcoh_if.sv
// Valid/ready channel interfaces: pixel input, bin output, configuration writes.
interface hcoh_pix_if import hcoh_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] magnitude;
    logic [DIR_W-1:0] direction;
    logic             last_in_cell;

    modport source (output valid, output magnitude, output direction, output last_in_cell,
                    input ready);
    modport sink   (input valid, input magnitude, input direction, input last_in_cell,
                    output ready);
endinterface

interface hcoh_bin_if import hcoh_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [BIN_IDX_W-1:0] bin_index;
    logic [BIN_VAL_W-1:0] bin_value;
    logic                 last_bin;

    modport source (output valid, output bin_index, output bin_value, output last_bin,
                    input ready);
    modport sink   (input valid, input bin_index, input bin_value, input last_bin,
                    output ready);
endinterface

interface hcoh_cfg_if import hcoh_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/hcoh_bin_math.sv
// Multi-cycle binning datapath: fold, bin position, bilinear weight and share.
module hcoh_bin_math import hcoh_pkg::*; #(
    parameter int MAX_BINS = MAX_BINS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [MAG_W-1:0]                     i_magnitude,
    input  logic [DIR_W-1:0]                     i_direction,
    input  t_cfg                                 i_cfg,
    input  logic [$clog2(MAX_BINS+1)-1:0]        i_nb,
    output logic                                 o_done,
    output logic [((MAX_BINS > 1) ? $clog2(MAX_BINS) : 1)-1:0] o_addr_a,
    output logic [MAG_W-1:0]                     o_val_a,
    output logic [((MAX_BINS > 1) ? $clog2(MAX_BINS) : 1)-1:0] o_addr_b,
    output logic [MAG_W-1:0]                     o_val_b,
    output logic                                 o_single
);

    localparam int IW     = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int NB_W   = $clog2(MAX_BINS + 1);
    localparam int Q_W    = POS_W - FRAC_BITS;
    localparam int CMP_W  = (Q_W > NB_W) ? Q_W : NB_W;
    localparam int PROD_W = IW + BIN_WIDTH_W + ANG_FRAC;
    localparam int D_W    = ((PROD_W > DIR_W) ? PROD_W : DIR_W) + 1;
    localparam int W_W    = D_W + BIN_SCALE_W + 2;
    localparam int SH_W   = MAG_W + AW_W;

    localparam logic [POS_W-1:0]        HALF_P  = POS_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [W_W-1:0]   HALF_W  = W_W'(1) << (FRAC_BITS - 1);
    localparam logic [W_W-1:0]          ONE_W   = W_W'(1) << FRAC_BITS;
    localparam logic [AW_W-1:0]         ONE_AW  = AW_W'(1) << FRAC_BITS;
    localparam logic [SH_W-1:0]         HALF_SH = SH_W'(1) << (FRAC_BITS - 1);

    // One token walks through the stages
    logic [5:0]               r_vld;
    logic                     r_done;

    logic [DIR_W-1:0]         r_theta;
    logic [MAG_W-1:0]         r_mag;
    logic [POS_W-1:0]         r_p;
    logic [IW-1:0]            r_idx;
    logic signed [D_W-1:0]    r_d;
    logic signed [W_W-1:0]    r_w;
    logic                     r_neg;
    logic [AW_W-1:0]          r_aw;
    logic [IW-1:0]            r_addr_a;
    logic [IW-1:0]            r_addr_b;
    logic [MAG_W-1:0]         r_val_a;
    logic [MAG_W-1:0]         r_val_b;
    logic                     r_single;

    logic [DIR_W-1:0]         tmax;
    logic [DIR_W-1:0]         theta;
    logic [POS_W-1:0]         p_adj;
    logic [Q_W-1:0]           q;
    logic [NB_W-1:0]          nb_m1;
    logic [IW-1:0]            idx;
    logic [PROD_W-1:0]        idx_deg;
    logic [W_W-1:0]           w_abs;
    logic [SH_W-1:0]          sh_prod;
    logic [MAG_W-1:0]         share;
    logic [IW-1:0]            nbr;

    always_comb begin
        tmax  = {i_cfg.theta_max, {ANG_FRAC{1'b0}}};
        theta = (i_direction > tmax) ? (i_direction - tmax) : i_direction;
    end

    // Bin position; bilinear centers sit half a bin in
    always_comb begin
        if (i_cfg.interp_mode == INTERP_NEAREST) begin
            p_adj = r_p;
        end else if (r_p >= HALF_P) begin
            p_adj = r_p - HALF_P;
        end else begin
            p_adj = '0;
        end
        q     = p_adj[POS_W-1:FRAC_BITS];
        nb_m1 = i_nb - NB_W'(1);
        if (CMP_W'(q) > CMP_W'(nb_m1)) begin
            idx = nb_m1[IW-1:0];
        end else begin
            idx = IW'(q);
        end
    end

    always_comb begin
        idx_deg = (PROD_W'(r_idx) * PROD_W'(i_cfg.bin_width)) << ANG_FRAC;
        w_abs   = r_w[W_W-1] ? W_W'(-r_w) : W_W'(r_w);
        sh_prod = SH_W'(r_mag) * SH_W'(r_aw) + HALF_SH;
        share   = sh_prod[FRAC_BITS +: MAG_W];
    end

    // Neighbor bin, wrapping at both ends
    always_comb begin
        if (!r_neg) begin
            nbr = ((NB_W'(r_idx) + NB_W'(1)) >= i_nb) ? '0 : (r_idx + IW'(1));
        end else begin
            nbr = (r_idx == '0) ? nb_m1[IW-1:0] : (r_idx - IW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[4:0], i_start};
            r_done <= r_vld[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_theta <= theta;
            r_mag   <= i_magnitude;
        end
        if (r_vld[0]) begin
            r_p <= POS_W'(r_theta) * POS_W'(i_cfg.bin_scale);
        end
        if (r_vld[1]) begin
            r_idx <= idx;
        end
        if (r_vld[2]) begin
            r_d <= $signed(D_W'(r_theta)) - $signed(D_W'(idx_deg));
        end
        if (r_vld[3]) begin
            r_w <= r_d * $signed({1'b0, i_cfg.bin_scale}) - HALF_W;
        end
        if (r_vld[4]) begin
            r_neg <= r_w[W_W-1];
            r_aw  <= (w_abs > ONE_W) ? ONE_AW : AW_W'(w_abs);
        end
        if (r_vld[5]) begin
            if (i_cfg.interp_mode == INTERP_NEAREST) begin
                r_addr_a <= r_idx;
                r_val_a  <= r_mag;
                r_addr_b <= r_idx;
                r_val_b  <= '0;
                r_single <= 1'b1;
            end else begin
                r_addr_a <= nbr;
                r_val_a  <= share;
                r_addr_b <= r_idx;
                r_val_b  <= r_mag - share;
                r_single <= 1'b0;
            end
        end
    end

    assign o_done   = r_done;
    assign o_addr_a = r_addr_a;
    assign o_val_a  = r_val_a;
    assign o_addr_b = r_addr_b;
    assign o_val_b  = r_val_b;
    assign o_single = r_single;

`ifndef SYNTHESIS
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_vld, r_done}))
        else $error("more than one pixel in the binning datapath");
`endif

endmodule

>>> rtl/hcoh_acc_mem.sv
// Bin accumulator memory: one read and one write port, per-entry valid bits.
module hcoh_acc_mem import hcoh_pkg::*; #(
    parameter int MAX_BINS = MAX_BINS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_mem_ctl                             i_ctl,
    input  logic [((MAX_BINS > 1) ? $clog2(MAX_BINS) : 1)-1:0] i_rd_addr,
    input  logic [((MAX_BINS > 1) ? $clog2(MAX_BINS) : 1)-1:0] i_wr_addr,
    input  logic [BIN_VAL_W-1:0]                 i_wr_data,
    output logic [BIN_VAL_W-1:0]                 o_rd_data
);

    logic [BIN_VAL_W-1:0] r_mem [MAX_BINS];
    logic [MAX_BINS-1:0]  r_valid;
    logic [BIN_VAL_W-1:0] r_rd_raw;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_raw <= r_mem[i_rd_addr];
        end
    end

    // Unwritten entries since the last clear read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.clr_all) begin
                r_valid <= '0;
            end else if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_raw : '0;

`ifndef SYNTHESIS
    a_clr_no_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clr_all |-> !i_ctl.wr_en)
        else $error("histogram clear collides with a bin write");
`endif

endmodule

>>> rtl/hog_cell_orientation_histogram_core.sv
// HOG cell orientation histogram: top level with sequencer, config registers and output stage.
//
// Channels: i_pix takes one gradient pixel per transaction (magnitude Q12.4, direction
// Q9.7, last_in_cell). o_bin delivers one histogram bin per transaction (bin_index,
// bin_value, last_bin). i_cfg writes one register per transaction (index, data); it is
// always ready and is meant to be written while the block is idle.
// Flow: a pixel runs through the binning datapath (fold, bin position multiply,
// bin index, offset, weight multiply, weight clamp, share multiply), then does a
// read-modify-write on the accumulator memory for one bin (nearest mode) or for
// two bins (bilinear). i_pix.ready drops when a pixel is taken and is high again
// only once that update, and any bin readout, is done, so a new pixel is not taken
// before the last one is through. The datapath depth and the serialized
// read-modify-write of the accumulator memory set the pixel rate.
// On a last_in_cell pixel the bins 0..nb-1 (num_bins forced into 1..MAX_BINS) are read
// out after the update, each read (S_ERD) and then loaded into the output register (S_ELD).
// A stalled o_bin holds the bin in the output register and pauses the readout.
// After the last bin is loaded the whole histogram is cleared at once by the valid bits.
// Reset: synchronous, active low; registers return to their reset values, the
// histogram reads as all zero and no transaction is pending.
module hog_cell_orientation_histogram_core import hcoh_pkg::*; #(
    parameter int MAX_BINS = MAX_BINS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hcoh_pix_if.sink      i_pix,
    hcoh_bin_if.source    o_bin,
    hcoh_cfg_if.sink      i_cfg
);

    localparam int IW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int NB_W  = $clog2(MAX_BINS + 1);
    localparam int NBC_W = (NB_W > NUM_BINS_W) ? NB_W : NUM_BINS_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MATH = 8'b0000_0010,
        S_RDA  = 8'b0000_0100,
        S_WRA  = 8'b0000_1000,
        S_RDB  = 8'b0001_0000,
        S_WRB  = 8'b0010_0000,
        S_ERD  = 8'b0100_0000,
        S_ELD  = 8'b1000_0000
    } t_state;

    // Configuration registers
    logic [NUM_BINS_W-1:0]  r_num_bins;
    t_cfg                   r_cfg;

    // Sequencer
    t_state                 r_state, n_state;
    logic                   r_last, n_last;
    logic [NB_W-1:0]        r_emit_cnt, n_emit_cnt;

    // Output register
    logic                   r_out_valid, n_out_valid;
    logic [BIN_IDX_W-1:0]   r_out_index;
    logic [BIN_VAL_W-1:0]   r_out_value;
    logic                   r_out_last;

    logic [NB_W-1:0]        nb;
    logic                   pix_acc;
    logic                   out_load;
    logic                   emit_last;

    logic                   math_done;
    logic [IW-1:0]          addr_a, addr_b;
    logic [MAG_W-1:0]       val_a, val_b;
    logic                   single;

    t_mem_ctl               mem_ctl;
    logic [IW-1:0]          rd_addr, wr_addr;
    logic [BIN_VAL_W-1:0]   rd_data, wr_data;
    logic [MAG_W-1:0]       add_val;
    logic [BIN_VAL_W:0]     sum;

    // Bins in use, forced into 1..MAX_BINS
    always_comb begin
        if (r_num_bins == '0) begin
            nb = NB_W'(1);
        end else if (NBC_W'(r_num_bins) > NBC_W'(MAX_BINS)) begin
            nb = NB_W'(MAX_BINS);
        end else begin
            nb = NB_W'(r_num_bins);
        end
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_bins        <= NUM_BINS_RST;
            r_cfg.theta_max   <= THETA_MAX_RST;
            r_cfg.bin_width   <= BIN_WIDTH_RST;
            r_cfg.bin_scale   <= BIN_SCALE_RST;
            r_cfg.interp_mode <= INTERP_MODE_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_NUM_BINS:    r_num_bins        <= i_cfg.data[NUM_BINS_W-1:0];
                CFG_THETA_MAX:   r_cfg.theta_max   <= i_cfg.data[THETA_MAX_W-1:0];
                CFG_BIN_WIDTH:   r_cfg.bin_width   <= i_cfg.data[BIN_WIDTH_W-1:0];
                CFG_BIN_SCALE:   r_cfg.bin_scale   <= i_cfg.data[BIN_SCALE_W-1:0];
                CFG_INTERP_MODE: r_cfg.interp_mode <= i_cfg.data[0];
                default: ;  // unknown index: dropped
            endcase
        end
    end

    assign i_pix.ready = (r_state == S_IDLE);
    assign pix_acc     = i_pix.valid && i_pix.ready;

    hcoh_bin_math #(.MAX_BINS(MAX_BINS)) u_math (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (pix_acc),
        .i_magnitude (i_pix.magnitude),
        .i_direction (i_pix.direction),
        .i_cfg       (r_cfg),
        .i_nb        (nb),
        .o_done      (math_done),
        .o_addr_a    (addr_a),
        .o_val_a     (val_a),
        .o_addr_b    (addr_b),
        .o_val_b     (val_b),
        .o_single    (single)
    );

    // Output register frees when the sink takes it
    assign out_load  = (r_state == S_ELD) && (!r_out_valid || o_bin.ready);
    assign emit_last = (r_emit_cnt == (nb - NB_W'(1)));

    // Saturating accumulate on the bin just read
    always_comb begin
        add_val = (r_state == S_WRB) ? val_b : val_a;
        sum     = {1'b0, rd_data} + (BIN_VAL_W+1)'(add_val);
        wr_data = sum[BIN_VAL_W] ? '1 : sum[BIN_VAL_W-1:0];
    end

    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        n_emit_cnt  = r_emit_cnt;
        mem_ctl     = '0;
        rd_addr     = addr_a;
        wr_addr     = addr_a;
        unique case (r_state)
            S_IDLE: begin
                if (pix_acc) begin
                    n_last  = i_pix.last_in_cell;
                    n_state = S_MATH;
                end
            end
            S_MATH: begin
                if (math_done) begin
                    n_state = S_RDA;
                end
            end
            S_RDA: begin
                mem_ctl.rd_en = 1'b1;
                n_state       = S_WRA;
            end
            S_WRA: begin
                mem_ctl.wr_en = 1'b1;
                if (!single) begin
                    n_state = S_RDB;
                end else if (r_last) begin
                    n_emit_cnt = '0;
                    n_state    = S_ERD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RDB: begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = addr_b;
                n_state       = S_WRB;
            end
            S_WRB: begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = addr_b;
                if (r_last) begin
                    n_emit_cnt = '0;
                    n_state    = S_ERD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ERD: begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = r_emit_cnt[IW-1:0];
                n_state       = S_ELD;
            end
            S_ELD: begin
                if (out_load) begin
                    if (emit_last) begin
                        mem_ctl.clr_all = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        n_emit_cnt = r_emit_cnt + NB_W'(1);
                        n_state    = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && !o_bin.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= 1'b0;
            r_emit_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_emit_cnt  <= n_emit_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_index <= BIN_IDX_W'(r_emit_cnt);
            r_out_value <= rd_data;
            r_out_last  <= emit_last;
        end
    end

    hcoh_acc_mem #(.MAX_BINS(MAX_BINS)) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    assign o_bin.valid     = r_out_valid;
    assign o_bin.bin_index = r_out_index;
    assign o_bin.bin_value = r_out_value;
    assign o_bin.last_bin  = r_out_last;

`ifndef SYNTHESIS
    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERD || r_state == S_ELD) |-> (r_emit_cnt < nb))
        else $error("bin readout ran past the bins in use");

    a_last_bin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && emit_last) |=> (r_state == S_IDLE && r_out_valid && r_out_last))
        else $error("final bin did not end the readout");
`endif

endmodule
